[hw/rtl/topt_pkg.sv]
// shared constants and types for the 2-opt tour optimiser
// no dependencies
`timescale 1ns / 1ps

package topt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int IDX_BITS   = 6;
    // one stored entry: index, y, x
    localparam int ENTRY_BITS = IDX_BITS + 2 * COORD_BITS;
    // squared distance and gain widths
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int GAIN_BITS  = SQ_BITS + 3;

    typedef logic [ENTRY_BITS-1:0] entry_t;
    typedef logic signed [GAIN_BITS-1:0] gain_t;

endpackage

[hw/rtl/two_opt_best_improvement.sv]
// Best-improvement 2-opt tour optimiser, top level.
// Uses topt_pkg and topt_ram (tour memory).
//
// Channels: s_axis takes points (tdata = coord_x, coord_y; tlast = last point).
// m_axis gives the optimised tour (tdata = out_x, out_y, point_index,
// overflow; tlast = final point). Up to MAX_POINTS points are stored; later
// ones are dropped and flagged on every output item of that tour.
// Loading accepts one point per cycle. On tlast, with at least four points
// stored, the block runs passes: each candidate pair (i, j) takes eight
// tour-memory reads, one per cycle, whose squared distances are summed into
// a gain and compared with the best; a chosen reversal costs two reads and
// two writes per swapped pair. Passes repeat until no gain is positive. The
// single read port of the tour memory is why a pair's reads go one at a time.
// Output goes through ST_EMITR, ST_EMITW and ST_EMITO for each point; the
// output register holds its item while m_axis_tready is low.
// Reset clears the point count, flags and the control state; the memory is
// not cleared. s_axis_tready is low from the last point until the final
// output item has been taken.
`timescale 1ns / 1ps

module two_opt_best_improvement (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // coord_x[15:0], coord_y[31:16]
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_x, out_y, point_index, overflow, zero bit
    output logic        m_axis_tlast    // last_out
);

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_PAIR  = 9'b000000010,  // issue reads of four entries
        ST_CALC  = 9'b000000100,  // distance accumulation
        ST_NEXT  = 9'b000001000,  // next pair
        ST_SWAPR = 9'b000010000,  // read lo/hi
        ST_SWAPW = 9'b000100000,  // write swapped
        ST_EMITR = 9'b001000000,
        ST_EMITW = 9'b010000000,
        ST_EMITO = 9'b100000000
    } state_t;

    localparam int AB = topt_pkg::ADDR_BITS;
    localparam int CB = topt_pkg::CNT_BITS;
    localparam int W  = topt_pkg::COORD_BITS;

    state_t state_reg, state_next;
    logic [CB-1:0] count_reg;
    logic          dropped_reg;
    logic [AB-1:0] i_reg, j_reg, lo_reg, hi_reg, k_reg;
    logic [2:0]    step_reg;      // read step within a pair
    logic [3:0]    dstep_reg;     // data step, following the registered read
    topt_pkg::gain_t gain_reg, best_gain_reg;
    logic [AB-1:0] best_i_reg, best_j_reg;
    topt_pkg::entry_t a_reg, lo_ent_reg;
    logic [W:0]    dx_reg, dy_reg;
    logic          sq_vld_reg, sq_sub_reg;
    logic [2*W+1:0] sq_reg;
    logic          sq2_vld_reg, sq2_sub_reg;

    // memory port
    logic          we;
    logic [AB-1:0] waddr, raddr;
    topt_pkg::entry_t wdata, rdata;

    topt_ram #(.WIDTH(topt_pkg::ENTRY_BITS), .DEPTH(topt_pkg::MAX_POINTS)) u_tour (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD);

    // read address schedule per pair: (i,i-1),(j,j+1),(i,j+1),(j,i-1)
    logic [AB-1:0] sched_addr;
    always_comb
    begin
        case (step_reg)
            3'd0: sched_addr = i_reg;
            3'd1: sched_addr = i_reg - AB'(1);
            3'd2: sched_addr = j_reg;
            3'd3: sched_addr = j_reg + AB'(1);
            3'd4: sched_addr = i_reg;
            3'd5: sched_addr = j_reg + AB'(1);
            3'd6: sched_addr = j_reg;
            default: sched_addr = i_reg - AB'(1);
        endcase
    end

    // memory access mux
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[AB-1:0];
        wdata = {count_reg[topt_pkg::IDX_BITS-1:0], s_axis_tdata[16 +: W], s_axis_tdata[0 +: W]};
        raddr = sched_addr;
        case (state_reg)
            ST_LOAD:
            begin
                we = in_acc && (count_reg < CB'(topt_pkg::MAX_POINTS));
            end
            ST_SWAPR:
            begin
                raddr = (step_reg == 3'd0) ? lo_reg : hi_reg;
            end
            ST_SWAPW:
            begin
                we    = 1'b1;
                waddr = (step_reg == 3'd0) ? lo_reg : hi_reg;
                wdata = (step_reg == 3'd0) ? rdata : lo_ent_reg;
            end
            ST_EMITR:
            begin
                raddr = k_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    logic [W:0] ax, ay, bx, by;
    assign ax = {1'b0, a_reg[0 +: W]};
    assign ay = {1'b0, a_reg[W +: W]};
    assign bx = {1'b0, rdata[0 +: W]};
    assign by = {1'b0, rdata[W +: W]};

    logic [CB-1:0] n3;
    assign n3 = count_reg - CB'(3);

    logic [W:0] dxm, dym;
    assign dxm = dx_reg[W] ? (~dx_reg + (W+1)'(1)) : dx_reg;
    assign dym = dy_reg[W] ? (~dy_reg + (W+1)'(1)) : dy_reg;

    logic [2*W+1:0] prod_x, prod_y;
    assign prod_x = {{W+1{1'b0}}, dxm} * {{W+1{1'b0}}, dxm};
    assign prod_y = {{W+1{1'b0}}, dym} * {{W+1{1'b0}}, dym};

    // read data of a pair is taken in the cycle after its address
    logic pair_data;
    assign pair_data = (state_reg == ST_PAIR || state_reg == ST_CALC) && (dstep_reg < 4'd8)
                       && (state_reg == ST_CALC || step_reg != 3'd0);

    // state register and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            step_reg      <= '0;
            dstep_reg     <= '0;
            sq_vld_reg    <= 1'b0;
            sq2_vld_reg   <= 1'b0;
            m_axis_tvalid <= 1'b0;
            best_gain_reg <= '0;
            best_i_reg    <= '0;
            best_j_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sq_vld_reg  <= pair_data && dstep_reg[0];
            sq2_vld_reg <= sq_vld_reg;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (count_reg < CB'(topt_pkg::MAX_POINTS))
                        begin
                            count_reg <= count_reg + CB'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        i_reg         <= AB'(1);
                        j_reg         <= AB'(2);
                        step_reg      <= '0;
                        dstep_reg     <= '0;
                        best_gain_reg <= '0;
                        best_i_reg    <= '0;
                        best_j_reg    <= '0;
                        k_reg         <= '0;
                        gain_reg      <= '0;
                    end
                end
                ST_PAIR:
                begin
                    // eight reads, one per cycle; read data is registered by the memory
                    if (step_reg == 3'd7)
                    begin
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                default:
                begin
                    // read step handled below in the other states
                end
            endcase

            // data side of pair reads: even steps latch a, odd form difference
            if (pair_data)
            begin
                if (!dstep_reg[0])
                begin
                    a_reg <= rdata;
                end
                else
                begin
                    dx_reg     <= ax - bx;
                    dy_reg     <= ay - by;
                    sq_sub_reg <= dstep_reg[2];
                end
                dstep_reg <= dstep_reg + 4'd1;
            end
            if (sq_vld_reg)
            begin
                sq_reg      <= prod_x + prod_y;
                sq2_sub_reg <= sq_sub_reg;
            end
            if (sq2_vld_reg)
            begin
                gain_reg <= sq2_sub_reg ? gain_reg - topt_pkg::gain_t'(sq_reg)
                                        : gain_reg + topt_pkg::gain_t'(sq_reg);
            end

            case (state_reg)
                ST_NEXT:
                begin
                    if (gain_reg > best_gain_reg)
                    begin
                        best_gain_reg <= gain_reg;
                        best_i_reg    <= i_reg;
                        best_j_reg    <= j_reg;
                    end
                    gain_reg  <= '0;
                    dstep_reg <= '0;
                    if ((CB)'(j_reg) + CB'(2) < count_reg)
                    begin
                        j_reg <= j_reg + AB'(1);
                    end
                    else
                    begin
                        i_reg <= i_reg + AB'(1);
                        j_reg <= i_reg + AB'(2);
                    end
                end
                ST_SWAPR:
                begin
                    if (step_reg == 3'd1)
                    begin
                        lo_ent_reg <= rdata;
                        step_reg   <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_SWAPW:
                begin
                    if (step_reg == 3'd1)
                    begin
                        step_reg <= '0;
                        lo_reg   <= lo_reg + AB'(1);
                        hi_reg   <= hi_reg - AB'(1);
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_EMITO:
                begin
                    if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        k_reg         <= k_reg + AB'(1);
                        if (m_axis_tlast)
                        begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                ST_EMITW:
                begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata  <= {1'b0, dropped_reg, rdata};
                    m_axis_tlast  <= ((CB)'(k_reg) + CB'(1) == count_reg);
                end
                default:
                begin
                    // output register holds its item
                end
            endcase

            // start of a pass or a reversal
            if ((state_reg == ST_NEXT && state_next == ST_SWAPR) )
            begin
                lo_reg <= (gain_reg > best_gain_reg) ? i_reg : best_i_reg;
                hi_reg <= (gain_reg > best_gain_reg) ? j_reg : best_j_reg;
            end
            if (state_reg == ST_SWAPW && state_next == ST_PAIR)
            begin
                i_reg         <= AB'(1);
                j_reg         <= AB'(2);
                best_gain_reg <= '0;
                best_i_reg    <= '0;
                best_j_reg    <= '0;
                gain_reg      <= '0;
                dstep_reg     <= '0;
            end
        end
    end

    // next state
    logic last_pair;
    assign last_pair = ((CB)'(i_reg) == n3) && ((CB)'(j_reg) + CB'(2) >= count_reg);
    logic better;
    assign better = (gain_reg > best_gain_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = (count_reg + ((count_reg < CB'(topt_pkg::MAX_POINTS))
                                  ? CB'(1) : CB'(0)) >= CB'(4)) ? ST_PAIR : ST_EMITR;
                end
            end
            ST_PAIR:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (dstep_reg == 4'd8 && !sq_vld_reg && !sq2_vld_reg)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!last_pair)
                begin
                    state_next = ST_PAIR;
                end
                else if (better || best_gain_reg > topt_pkg::gain_t'(0))
                begin
                    state_next = ST_SWAPR;
                end
                else
                begin
                    state_next = ST_EMITR;
                end
            end
            ST_SWAPR:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = ST_PAIR;
                end
                else if (step_reg == 3'd1)
                begin
                    state_next = ST_SWAPW;
                end
            end
            ST_SWAPW:
            begin
                if (step_reg == 3'd1)
                begin
                    state_next = (lo_reg + AB'(1) < hi_reg - AB'(1)) ? ST_SWAPR : ST_PAIR;
                end
            end
            ST_EMITR:
            begin
                state_next = ST_EMITW;
            end
            ST_EMITW:
            begin
                state_next = ST_EMITO;
            end
            ST_EMITO:
            begin
                if (m_axis_tready)
                begin
                    state_next = m_axis_tlast ? ST_LOAD : ST_EMITR;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // no input item taken while optimising or emitting
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("input accepted while busy");
    // stored count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(topt_pkg::MAX_POINTS))
        else $error("point count beyond capacity");
    // a reversal always has lo below hi when it starts writing
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAPW) |-> (lo_reg < hi_reg))
        else $error("reversal span out of order");
    // best gain never negative
    a_gain_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !best_gain_reg[topt_pkg::GAIN_BITS-1])
        else $error("best gain negative");
`endif

endmodule

[hw/rtl/topt_ram.sv]
// generic single-port-write, one-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module topt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
